// ----- rtl/assert_macros.svh -----
// Assertion macros for the checker module of the list block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition a implies condition c in the same cycle, outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed: same-cycle implication");

// Condition a implies condition c in the following cycle, outside reset.
`define ASSERT_IMPLIES_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed: next-cycle implication");

// Condition a implies condition c in the following cycle, checked during reset too.
`define ASSERT_ALWAYS_NEXT(label, clk, a, c) \
    label: assert property (@(posedge clk) (a) |=> (c)) \
        else $error("assertion failed: reset behaviour");

`endif

// ----- rtl/pal_pkg.sv -----
// Package for the positional array list: sizes, codes and shared types.
// No dependencies; used by the cell, read-out tree and top-level modules of the block.
`timescale 1ns / 1ps

package pal_pkg;

    // Store geometry.
    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    // Field widths of the transactions.
    localparam int CMD_W = 2;
    localparam int POS_W = 7;
    localparam int VAL_W = 32;
    localparam int LEN_W = 7;

    // Width used when comparing a position against the count.
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_BITS  = CMD_W + POS_W + VAL_W;
    localparam int OUT_BITS = 1 + VAL_W + LEN_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Read-out tree: cells are ORed in groups of this size.
    localparam int GROUP   = 8;
    localparam int NGROUPS = (DEPTH + GROUP - 1) / GROUP;

    // Request codes.
    localparam logic [CMD_W-1:0] CMD_READ   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DELETE = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SHIFT  = 4'b0010,
        ST_REDUCE = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    // Operation broadcast to every cell of the row.
    typedef struct packed {
        logic                  rd;
        logic                  ins;
        logic                  del;
        logic [IDX_W-1:0]      slot;
        logic [DATA_WIDTH-1:0] value;
    } cell_ctrl_t;

endpackage

// ----- rtl/pal_cell.sv -----
// One storage cell of the list row: holds one entry and trades it with neighbours.
// Depends on pal_pkg.
`timescale 1ns / 1ps

module pal_cell (
    input  logic                           aclk,
    input  logic                           en,
    input  pal_pkg::cell_ctrl_t            ctrl,
    input  logic [pal_pkg::IDX_W-1:0]      my_index,
    input  logic [pal_pkg::DATA_WIDTH-1:0] left_value,
    input  logic [pal_pkg::DATA_WIDTH-1:0] right_value,
    output logic [pal_pkg::DATA_WIDTH-1:0] value,
    output logic [pal_pkg::DATA_WIDTH-1:0] tap
);

    logic [pal_pkg::DATA_WIDTH-1:0] value_reg;
    logic [pal_pkg::DATA_WIDTH-1:0] value_next;
    logic [pal_pkg::DATA_WIDTH-1:0] tap_reg;
    logic [pal_pkg::DATA_WIDTH-1:0] tap_next;
    logic                           hit;
    logic                           above;

    assign hit   = (my_index == ctrl.slot);
    assign above = (my_index > ctrl.slot);

    // An insert moves entries up from the slot, a delete pulls them down.
    always_comb begin
        value_next = value_reg;
        if (ctrl.ins && hit) begin
            value_next = ctrl.value;
        end else if (ctrl.ins && above) begin
            value_next = left_value;
        end else if (ctrl.del && (hit || above)) begin
            value_next = right_value;
        end
    end

    // The addressed cell presents its old entry to the read-out tree.
    assign tap_next = (hit && (ctrl.rd || ctrl.del)) ? value_reg : '0;

    always_ff @(posedge aclk) begin
        if (en) begin
            value_reg <= value_next;
            tap_reg   <= tap_next;
        end
    end

    assign value = value_reg;
    assign tap   = tap_reg;

endmodule

// ----- rtl/pal_reduce.sv -----
// Registered OR tree that collects the single non-zero cell tap.
// Depends on pal_pkg.
`timescale 1ns / 1ps

module pal_reduce (
    input  logic                           aclk,
    input  logic                           en,
    input  logic [pal_pkg::DATA_WIDTH-1:0] taps [pal_pkg::DEPTH],
    output logic [pal_pkg::DATA_WIDTH-1:0] result
);

    logic [pal_pkg::DATA_WIDTH-1:0] padded     [pal_pkg::NGROUPS * pal_pkg::GROUP];
    logic [pal_pkg::DATA_WIDTH-1:0] group_reg  [pal_pkg::NGROUPS];
    logic [pal_pkg::DATA_WIDTH-1:0] group_next [pal_pkg::NGROUPS];

    // Pad the tap row to whole groups.
    always_comb begin
        for (int i = 0; i < pal_pkg::NGROUPS * pal_pkg::GROUP; i++) begin
            padded[i] = (i < pal_pkg::DEPTH) ? taps[i] : '0;
        end
    end

    // First level: OR within each group.
    always_comb begin
        for (int g = 0; g < pal_pkg::NGROUPS; g++) begin
            group_next[g] = '0;
            for (int k = 0; k < pal_pkg::GROUP; k++) begin
                group_next[g] = group_next[g] | padded[g * pal_pkg::GROUP + k];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int g = 0; g < pal_pkg::NGROUPS; g++) begin
                group_reg[g] <= group_next[g];
            end
        end
    end

    // Second level: OR across the group registers.
    always_comb begin
        result = '0;
        for (int g = 0; g < pal_pkg::NGROUPS; g++) begin
            result = result | group_reg[g];
        end
    end

endmodule

// ----- rtl/positional_array_list_top.sv -----
// Positional array list: a row of entry cells with a request sequencer and read-out tree.
// Depends on pal_pkg, pal_cell and pal_reduce.
// Each request runs through the accept, shift, tree and output steps (idle, shift, reduce, finish)
// before its result enters the output register; the next request is taken only back in the idle state.
// The next request is taken while a finished result still waits in the output register.
// Reset (aresetn low, synchronous) empties the list and the output; entries need no clearing.
`timescale 1ns / 1ps

module positional_array_list_top (
    input  logic                      aclk,
    input  logic                      aresetn,
    // s_tdata: command [1:0], position [8:2], value_in [40:9], zero pad above
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [pal_pkg::IN_W-1:0]  s_tdata,
    // m_tdata: status [0], value_out [32:1], list_length [39:33]
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [pal_pkg::OUT_W-1:0] m_tdata
);

    pal_pkg::state_t                state_reg;
    pal_pkg::state_t                state_next;
    logic [pal_pkg::CNT_W-1:0]      count_reg;
    logic [pal_pkg::CNT_W-1:0]      count_next;
    pal_pkg::cell_ctrl_t            ctrl_reg;
    pal_pkg::cell_ctrl_t            ctrl_next;
    logic                           status_reg;
    logic [pal_pkg::CNT_W-1:0]      len_reg;
    logic                           m_tvalid_reg;
    logic [pal_pkg::OUT_W-1:0]      m_tdata_reg;

    logic [pal_pkg::CMD_W-1:0]      cmd;
    logic [pal_pkg::POS_W-1:0]      pos;
    logic [pal_pkg::VAL_W-1:0]      vin;
    logic [pal_pkg::CMP_W-1:0]      pos_x;
    logic [pal_pkg::CMP_W-1:0]      cnt_x;
    logic                           in_range;
    logic                           ins_ok;
    logic                           req_ok;
    logic                           accept;
    logic                           out_free;
    logic [pal_pkg::DATA_WIDTH-1:0] cell_value [pal_pkg::DEPTH];
    logic [pal_pkg::DATA_WIDTH-1:0] cell_tap   [pal_pkg::DEPTH];
    logic [pal_pkg::DATA_WIDTH-1:0] read_value;

    // Unpack the request transaction.
    assign cmd = s_tdata[1:0];
    assign pos = s_tdata[8:2];
    assign vin = s_tdata[40:9];

    assign s_tready = (state_reg == pal_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;

    // Position checks against the current length.
    assign pos_x    = pal_pkg::CMP_W'(pos);
    assign cnt_x    = pal_pkg::CMP_W'(count_reg);
    assign in_range = (pos != '0) && (pos_x <= cnt_x);
    assign ins_ok   = (count_reg < pal_pkg::CNT_W'(pal_pkg::DEPTH)) && (pos != '0) &&
                      (pos_x <= cnt_x + pal_pkg::CMP_W'(1));

    // Decode the request into a cell operation and the new length.
    always_comb begin
        ctrl_next       = '0;
        ctrl_next.slot  = pal_pkg::IDX_W'(pos - pal_pkg::POS_W'(1));
        ctrl_next.value = pal_pkg::DATA_WIDTH'(vin);
        count_next      = count_reg;
        req_ok          = 1'b0;
        case (cmd)
            pal_pkg::CMD_READ: begin
                req_ok       = in_range;
                ctrl_next.rd = in_range;
            end
            pal_pkg::CMD_INSERT: begin
                req_ok        = ins_ok;
                ctrl_next.ins = ins_ok;
                if (ins_ok) begin
                    count_next = count_reg + pal_pkg::CNT_W'(1);
                end
            end
            pal_pkg::CMD_DELETE: begin
                req_ok        = in_range;
                ctrl_next.del = in_range;
                if (in_range) begin
                    count_next = count_reg - pal_pkg::CNT_W'(1);
                end
            end
            default: begin
                req_ok = 1'b0;
            end
        endcase
    end

    // Sequencer: shift the row, collect the tap, then hand over the result.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            pal_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = pal_pkg::ST_SHIFT;
                end
            end
            pal_pkg::ST_SHIFT: begin
                state_next = pal_pkg::ST_REDUCE;
            end
            pal_pkg::ST_REDUCE: begin
                state_next = pal_pkg::ST_FINISH;
            end
            pal_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = pal_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pal_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= pal_pkg::ST_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (accept) begin
                count_reg <= count_next;
            end
            if (state_reg == pal_pkg::ST_FINISH && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Request payload held for the rest of the transaction, and the output data register.
    always_ff @(posedge aclk) begin
        if (accept) begin
            ctrl_reg   <= ctrl_next;
            status_reg <= !req_ok;
            len_reg    <= count_next;
        end
        if (state_reg == pal_pkg::ST_FINISH && out_free) begin
            m_tdata_reg <= pal_pkg::OUT_W'({pal_pkg::LEN_W'(len_reg),
                                            pal_pkg::VAL_W'(read_value),
                                            status_reg});
        end
    end

    // Row of cells, each linked to its two neighbours.
    for (genvar i = 0; i < pal_pkg::DEPTH; i++) begin : g_cell
        logic [pal_pkg::DATA_WIDTH-1:0] left_value;
        logic [pal_pkg::DATA_WIDTH-1:0] right_value;

        if (i == 0) begin : g_first
            assign left_value = '0;
        end else begin : g_left
            assign left_value = cell_value[i-1];
        end

        if (i == pal_pkg::DEPTH - 1) begin : g_last
            assign right_value = '0;
        end else begin : g_right
            assign right_value = cell_value[i+1];
        end

        pal_cell u_cell (
            .aclk        (aclk),
            .en          (state_reg == pal_pkg::ST_SHIFT),
            .ctrl        (ctrl_reg),
            .my_index    (pal_pkg::IDX_W'(i)),
            .left_value  (left_value),
            .right_value (right_value),
            .value       (cell_value[i]),
            .tap         (cell_tap[i])
        );
    end

    // Read-out tree over the cell taps.
    pal_reduce u_reduce (
        .aclk   (aclk),
        .en     (state_reg == pal_pkg::ST_REDUCE),
        .taps   (cell_tap),
        .result (read_value)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/pal_checker.sv -----
// Port-level checker for the positional array list, bound to the top level.
// Depends on assert_macros.svh and positional_array_list_top.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pal_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A result waiting on the output side keeps its contents.
    `ASSERT_IMPLIES_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

    // Reset leaves no result on the output side.
    `ASSERT_ALWAYS_NEXT(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // One request is worked on at a time.
    `ASSERT_IMPLIES_NEXT(a_one_at_a_time, aclk, aresetn, s_tvalid && s_tready, !s_tready)

    // A refused request returns a zero value.
    `ASSERT_IMPLIES(a_refused_zero, aclk, aresetn, m_tvalid && m_tdata[0], m_tdata[32:1] == '0)

    // The reported length never exceeds the capacity of sixty-four entries.
    `ASSERT_IMPLIES(a_len_bound, aclk, aresetn, m_tvalid, m_tdata[39:33] <= 7'd64)

endmodule

bind positional_array_list_top pal_checker u_pal_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
